// ===== hw/rtl/bscc_pkg.sv =====
// Shared types, constants and codes for the coulomb-counting state-of-charge block.
`default_nettype none

package bscc_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_NOMINAL_CAPACITY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_CHARGE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EMPTY_VOLTAGE    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_VOLTAGE     = 2'd3;

  localparam logic [14:0] NOMINAL_CAPACITY_RST = 15'd1000;
  localparam logic [14:0] INITIAL_CHARGE_RST   = 15'd1000;
  localparam logic [14:0] EMPTY_VOLTAGE_RST    = 15'd2500;
  localparam logic [14:0] FULL_VOLTAGE_RST     = 15'd4000;

  // charge counter unit is 0.1 A * 1 ms
  localparam logic [39:0] UNITS_PER_DAH      = 40'd3600000;
  localparam logic [39:0] UNITS_PER_CENTIPCT = 40'd360;
  localparam logic [39:0] REM_SAT_UNITS      = 40'd235929600000;
  localparam logic [39:0] CHARGE_MAX         = 40'hFF_FFFF_FFFF;
  localparam logic [39:0] SOC_SCALE          = 40'd10000;

  localparam logic [13:0]        SOC_FULL       = 14'd10000;
  localparam logic [13:0]        SOC_LOW_LIMIT  = 14'd200;
  localparam logic [13:0]        SOC_HIGH_LIMIT = 14'd9950;
  localparam logic signed [14:0] SOC_WINDOW     = 15'sd200;
  localparam logic signed [17:0] BIAS_DA        = 18'sd10000;
  localparam logic [15:0]        REM_MAX        = 16'hFFFF;

  // last quotient bit index for each division
  localparam logic [3:0] TDIV_LAST = 4'd13;
  localparam logic [3:0] SDIV_LAST = 4'd13;
  localparam logic [3:0] RDIV_LAST = 4'd15;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ZONE,
    S_TDIV,
    S_ACC,
    S_UPD,
    S_SOC,
    S_SDIV,
    S_REM,
    S_RDIV,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic        start;
    logic [39:0] dividend;
    logic [39:0] divisor_al;
    logic [3:0]  last_step;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bscc_in_if.sv =====
// Tick channel: currents, pack voltage and elapsed time.
`default_nettype none

interface bscc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] motor_current_da;
  logic signed [15:0] charger_current_da;
  logic [14:0]        pack_voltage_dv;
  logic [19:0]        elapsed_ms;

  modport source (
    output valid, motor_current_da, charger_current_da, pack_voltage_dv, elapsed_ms,
    input  ready
  );
  modport sink (
    input  valid, motor_current_da, charger_current_da, pack_voltage_dv, elapsed_ms,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/bscc_out_if.sv =====
// Result channel: state of charge, target, permission flags and remaining charge.
`default_nettype none

interface bscc_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] soc_centipct;
  logic [13:0] target_soc_centipct;
  logic        charge_ok;
  logic        discharge_ok;
  logic [15:0] remaining_charge_dah;

  modport source (
    output valid, soc_centipct, target_soc_centipct, charge_ok, discharge_ok,
           remaining_charge_dah,
    input  ready
  );
  modport sink (
    input  valid, soc_centipct, target_soc_centipct, charge_ok, discharge_ok,
           remaining_charge_dah,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/bscc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module bscc_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bscc_pkg::div_req_t req,
  output bscc_pkg::div_rsp_t     rsp
);

  logic [39:0] rem_acc;
  logic [39:0] dsr;
  logic [15:0] quot;
  logic [3:0]  step;
  logic        busy;
  logic        done;
  logic        fits;

  assign fits = rem_acc >= dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == 4'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_acc <= req.dividend;
      dsr     <= req.divisor_al;
      step    <= req.last_step;
      quot    <= '0;
    end else if (busy) begin
      if (fits) begin
        rem_acc <= rem_acc - dsr;
      end
      quot <= {quot[14:0], fits};
      dsr  <= dsr >> 1;
      step <= step - 4'd1;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

`default_nettype wire

// ===== hw/rtl/battery_soc_coulomb_counter_top.sv =====
// Top level: tick sequencer, charge counter and state-of-charge datapath.
// The first tick after reset only loads the counter and remaining charge and goes straight from
// idle to done; later ticks make up to three passes through the one shared restoring divider
// (target 14 bits, state of charge 14 bits, remaining charge 16 bits), which retires one quotient
// bit per cycle; a pass is skipped when its result is clamped or fixed.
// The tick channel is ready only while the sequencer is idle, and a finished result sits in the
// output register, so the next tick may be taken while the result still waits for its transfer.
`default_nettype none

module battery_soc_coulomb_counter_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  bscc_in_if.sink                               tick,
  bscc_out_if.source                            result,
  input  wire logic                             cfg_we,
  input  wire logic [bscc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bscc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bscc_pkg::seq_state_t state;
  bscc_pkg::seq_state_t state_next;
  bscc_pkg::div_req_t   div_req;
  bscc_pkg::div_rsp_t   div_rsp;

  logic [14:0] nominal_capacity;
  logic [14:0] initial_charge;
  logic [14:0] empty_voltage;
  logic [14:0] full_voltage;

  logic        first_tick;
  logic [39:0] charge_count;
  logic [13:0] soc_value;
  logic        charge_allowed;
  logic        discharge_allowed;

  logic signed [15:0] motor_da;
  logic signed [15:0] charger_da;
  logic [14:0]        pack_dv;
  logic [19:0]        elapsed;
  logic [13:0]        target;
  logic               corr;
  logic               low;
  logic signed [38:0] prod;
  logic [15:0]        rem;

  // voltage zone
  logic signed [15:0] span;
  logic [17:0]        v5;
  logic [17:0]        e5;
  logic [17:0]        f5;
  logic signed [19:0] lo_lim;
  logic signed [19:0] hi_lim;
  logic               low_c;
  logic               high_c;
  logic               zone_hit;
  logic               v_above;
  logic [15:0]        vdiff;
  logic               v_sat;
  logic               tdiv_go;

  // net current and counter update
  logic signed [14:0] tdiff;
  logic               far;
  logic signed [17:0] net_base;
  logic signed [17:0] bias;
  logic signed [17:0] net;
  logic signed [38:0] prod_calc;
  logic signed [41:0] cc_sum;
  logic [39:0]        cc_sat;

  // state of charge and remaining charge
  logic [39:0] cap_units;
  logic        soc_full_hit;
  logic        sdiv_go;
  logic        rem_sat;

  bscc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign span     = $signed({1'b0, full_voltage}) - $signed({1'b0, empty_voltage});
  assign v5       = {3'b000, pack_dv} * 18'd5;
  assign e5       = {3'b000, empty_voltage} * 18'd5;
  assign f5       = {3'b000, full_voltage} * 18'd5;
  assign lo_lim   = $signed({2'b00, e5}) + $signed({{4{span[15]}}, span});
  assign hi_lim   = $signed({2'b00, f5}) - $signed({{4{span[15]}}, span});
  assign low_c    = $signed({2'b00, v5}) < lo_lim;
  assign high_c   = $signed({2'b00, v5}) > hi_lim;
  assign zone_hit = !span[15] && (span != 16'sd0) && (low_c || high_c);
  assign v_above  = pack_dv > empty_voltage;
  assign vdiff    = {1'b0, pack_dv} - {1'b0, empty_voltage};
  assign v_sat    = vdiff[14:0] >= span[14:0];
  assign tdiv_go  = zone_hit && v_above && !v_sat;

  assign tdiff     = $signed({1'b0, target}) - $signed({1'b0, soc_value});
  assign far       = (tdiff > bscc_pkg::SOC_WINDOW) || (tdiff < -bscc_pkg::SOC_WINDOW);
  assign net_base  = $signed({{2{motor_da[15]}}, motor_da})
                   - $signed({{2{charger_da[15]}}, charger_da});
  assign bias      = (corr && far) ? (low ? bscc_pkg::BIAS_DA : -bscc_pkg::BIAS_DA) : 18'sd0;
  assign net       = net_base + bias;
  assign prod_calc = $signed({{21{net[17]}}, net}) * $signed({19'b0, elapsed});
  assign cc_sum    = $signed({2'b00, charge_count}) - $signed({{3{prod[38]}}, prod});
  assign cc_sat    = cc_sum[41] ? 40'd0 :
                     (cc_sum[40] ? bscc_pkg::CHARGE_MAX : cc_sum[39:0]);

  assign cap_units    = 40'(nominal_capacity) * bscc_pkg::UNITS_PER_DAH;
  assign soc_full_hit = charge_count >= cap_units;
  assign sdiv_go      = (nominal_capacity != 15'd0) && !soc_full_hit;
  assign rem_sat      = charge_count >= bscc_pkg::REM_SAT_UNITS;

  assign tick.ready = (state == bscc_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bscc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    div_req.start      = 1'b0;
    div_req.dividend   = charge_count;
    div_req.divisor_al = 40'(bscc_pkg::UNITS_PER_DAH << 15);
    div_req.last_step  = bscc_pkg::RDIV_LAST;
    unique case (state)
      bscc_pkg::S_IDLE: begin
        if (tick.valid) begin
          state_next = first_tick ? bscc_pkg::S_DONE : bscc_pkg::S_ZONE;
        end
      end
      bscc_pkg::S_ZONE: begin
        div_req.dividend   = 40'(vdiff[14:0]) * bscc_pkg::SOC_SCALE;
        div_req.divisor_al = 40'(span[14:0]) << 13;
        div_req.last_step  = bscc_pkg::TDIV_LAST;
        div_req.start      = tdiv_go;
        state_next         = tdiv_go ? bscc_pkg::S_TDIV : bscc_pkg::S_ACC;
      end
      bscc_pkg::S_TDIV: begin
        if (div_rsp.done) begin
          state_next = bscc_pkg::S_ACC;
        end
      end
      bscc_pkg::S_ACC: begin
        state_next = bscc_pkg::S_UPD;
      end
      bscc_pkg::S_UPD: begin
        state_next = bscc_pkg::S_SOC;
      end
      bscc_pkg::S_SOC: begin
        div_req.divisor_al = (40'(nominal_capacity) * bscc_pkg::UNITS_PER_CENTIPCT) << 13;
        div_req.last_step  = bscc_pkg::SDIV_LAST;
        div_req.start      = sdiv_go;
        state_next         = sdiv_go ? bscc_pkg::S_SDIV : bscc_pkg::S_REM;
      end
      bscc_pkg::S_SDIV: begin
        if (div_rsp.done) begin
          state_next = bscc_pkg::S_REM;
        end
      end
      bscc_pkg::S_REM: begin
        div_req.start = !rem_sat;
        state_next    = rem_sat ? bscc_pkg::S_DONE : bscc_pkg::S_RDIV;
      end
      bscc_pkg::S_RDIV: begin
        if (div_rsp.done) begin
          state_next = bscc_pkg::S_DONE;
        end
      end
      bscc_pkg::S_DONE: begin
        if (!result.valid || result.ready) begin
          state_next = bscc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bscc_pkg::S_IDLE;
      end
    endcase
  end

  // configuration and held state
  always_ff @(posedge clk) begin
    if (rst) begin
      nominal_capacity  <= bscc_pkg::NOMINAL_CAPACITY_RST;
      initial_charge    <= bscc_pkg::INITIAL_CHARGE_RST;
      empty_voltage     <= bscc_pkg::EMPTY_VOLTAGE_RST;
      full_voltage      <= bscc_pkg::FULL_VOLTAGE_RST;
      first_tick        <= 1'b1;
      soc_value         <= '0;
      charge_allowed    <= 1'b1;
      discharge_allowed <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bscc_pkg::REG_NOMINAL_CAPACITY: nominal_capacity <= cfg_data;
          bscc_pkg::REG_INITIAL_CHARGE:   initial_charge   <= cfg_data;
          bscc_pkg::REG_EMPTY_VOLTAGE:    empty_voltage    <= cfg_data;
          bscc_pkg::REG_FULL_VOLTAGE:     full_voltage     <= cfg_data;
          default: ;
        endcase
      end
      if (state == bscc_pkg::S_IDLE && tick.valid) begin
        first_tick <= 1'b0;
      end
      if (state == bscc_pkg::S_UPD) begin
        discharge_allowed <= soc_value >= bscc_pkg::SOC_LOW_LIMIT;
        charge_allowed    <= soc_value <= bscc_pkg::SOC_HIGH_LIMIT;
      end
      if (state == bscc_pkg::S_SOC) begin
        if (nominal_capacity == 15'd0) begin
          soc_value <= '0;
        end else if (soc_full_hit) begin
          soc_value <= bscc_pkg::SOC_FULL;
        end
      end
      if (state == bscc_pkg::S_SDIV && div_rsp.done) begin
        soc_value <= div_rsp.quot[13:0];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      bscc_pkg::S_IDLE: begin
        if (tick.valid) begin
          motor_da   <= tick.motor_current_da;
          charger_da <= tick.charger_current_da;
          pack_dv    <= tick.pack_voltage_dv;
          elapsed    <= tick.elapsed_ms;
          target     <= soc_value;
          corr       <= 1'b0;
          if (first_tick) begin
            charge_count <= 40'(initial_charge) * bscc_pkg::UNITS_PER_DAH;
            rem          <= 16'(initial_charge);
          end
        end
      end
      bscc_pkg::S_ZONE: begin
        corr <= zone_hit;
        low  <= low_c;
        if (zone_hit && !v_above) begin
          target <= '0;
        end else if (zone_hit && v_sat) begin
          target <= bscc_pkg::SOC_FULL;
        end
      end
      bscc_pkg::S_TDIV: begin
        if (div_rsp.done) begin
          target <= div_rsp.quot[13:0];
        end
      end
      bscc_pkg::S_ACC: begin
        prod <= prod_calc;
      end
      bscc_pkg::S_UPD: begin
        charge_count <= cc_sat;
      end
      bscc_pkg::S_REM: begin
        if (rem_sat) begin
          rem <= bscc_pkg::REM_MAX;
        end
      end
      bscc_pkg::S_RDIV: begin
        if (div_rsp.done) begin
          rem <= div_rsp.quot;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == bscc_pkg::S_DONE && (!result.valid || result.ready)) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bscc_pkg::S_DONE && (!result.valid || result.ready)) begin
      result.soc_centipct         <= soc_value;
      result.target_soc_centipct  <= target;
      result.charge_ok            <= charge_allowed;
      result.discharge_ok         <= discharge_allowed;
      result.remaining_charge_dah <= rem;
    end
  end

`ifndef ASSERT_OFF
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_tick_div_idle: assert property (@(posedge clk) disable iff (rst)
    (tick.valid && tick.ready) |-> !div_rsp.busy)
    else $error("tick transfer while divider busy");

  a_soc_range: assert property (@(posedge clk) disable iff (rst)
    soc_value <= bscc_pkg::SOC_FULL)
    else $error("state of charge out of range");

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.target_soc_centipct <= bscc_pkg::SOC_FULL))
    else $error("target state of charge out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_battery_soc_coulomb_counter_top.sv =====
// Self-checking testbench for the coulomb-counting state-of-charge block.

typedef struct packed {
  logic signed [15:0] motor_da;
  logic signed [15:0] charger_da;
  logic [14:0]        volts_dv;
  logic [19:0]        elapsed_ms;
} tick_t;

typedef struct packed {
  logic [13:0] soc;
  logic [13:0] target;
  logic        charge_ok;
  logic        discharge_ok;
  logic [15:0] remaining_dah;
} soc_out_t;

class soc_ledger;
  localparam longint UNITS_DAH  = 3600000;
  localparam longint COUNT_CEIL = 64'hFF_FFFF_FFFF;
  localparam longint SOC_TOP    = 10000;
  localparam longint SOC_WINDOW = 200;
  localparam longint BIAS       = 10000;
  localparam longint SOC_LOW    = 200;
  localparam longint SOC_HIGH   = 9950;

  logic [14:0] cap_dah;
  logic [14:0] init_dah;
  logic [14:0] empty_dv;
  logic [14:0] full_dv;
  bit          first_pending;
  longint      coulombs;
  longint      soc_held;
  bit          may_charge;
  bit          may_discharge;
  soc_out_t    soc_due[$];
  int          mismatches;

  function new();
    cap_dah       = 15'd1000;
    init_dah      = 15'd1000;
    empty_dv      = 15'd2500;
    full_dv       = 15'd4000;
    first_pending = 1'b1;
    coulombs      = 0;
    soc_held      = 0;
    may_charge    = 1'b1;
    may_discharge = 1'b1;
    mismatches    = 0;
  endfunction

  function void write_reg(logic [bscc_pkg::CFG_INDEX_W-1:0] idx,
                          logic [bscc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      bscc_pkg::REG_NOMINAL_CAPACITY: cap_dah = data;
      bscc_pkg::REG_INITIAL_CHARGE:   init_dah = data;
      bscc_pkg::REG_EMPTY_VOLTAGE:    empty_dv = data;
      bscc_pkg::REG_FULL_VOLTAGE:     full_dv = data;
      default: ;
    endcase
  endfunction

  function longint clamp_soc(longint s);
    if (s < 0) return 0;
    if (s > SOC_TOP) return SOC_TOP;
    return s;
  endfunction

  function soc_out_t advance_soc(tick_t t);
    longint   net, span, lo, hi, v, tgt, gap, cap_units, dah;
    bit       in_low, in_high;
    soc_out_t r;
    tgt = soc_held;
    if (first_pending) begin
      first_pending = 1'b0;
      coulombs = longint'(init_dah) * UNITS_DAH;
    end else begin
      net  = longint'($signed(t.motor_da)) - longint'($signed(t.charger_da));
      lo   = longint'(empty_dv);
      hi   = longint'(full_dv);
      v    = longint'(t.volts_dv);
      span = hi - lo;
      if (span > 0) begin
        in_low  = (5 * v) < (5 * lo + span);
        in_high = (5 * v) > (5 * hi - span);
        if (in_low || in_high) begin
          tgt = (v > lo) ? clamp_soc((v - lo) * SOC_TOP / span) : 0;
          gap = tgt - soc_held;
          if (gap < 0) gap = -gap;
          if (gap > SOC_WINDOW) net += in_low ? BIAS : -BIAS;
        end
      end
      may_discharge = soc_held >= SOC_LOW;
      may_charge    = soc_held <= SOC_HIGH;
      coulombs -= net * longint'(t.elapsed_ms);
      if (coulombs < 0) coulombs = 0;
      if (coulombs > COUNT_CEIL) coulombs = COUNT_CEIL;
      cap_units = longint'(cap_dah) * UNITS_DAH;
      if (cap_units == 0) soc_held = 0;
      else soc_held = clamp_soc(coulombs * SOC_TOP / cap_units);
    end
    dah = coulombs / UNITS_DAH;
    r.soc           = soc_held[13:0];
    r.target        = tgt[13:0];
    r.charge_ok     = may_charge;
    r.discharge_ok  = may_discharge;
    r.remaining_dah = (dah > 65535) ? 16'hFFFF : dah[15:0];
    return r;
  endfunction

  function void log_tick(tick_t t);
    soc_due = {soc_due, advance_soc(t)};
  endfunction

  function void match_result(soc_out_t got);
    soc_out_t want;
    if (soc_due.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected result: soc %0d target %0d chg %0b dis %0b rem %0d",
                 got.soc, got.target, got.charge_ok, got.discharge_ok, got.remaining_dah);
      mismatches++;
    end else begin
      want = soc_due.pop_front();
      if (got.soc !== want.soc || got.target !== want.target ||
          got.charge_ok !== want.charge_ok || got.discharge_ok !== want.discharge_ok ||
          got.remaining_dah !== want.remaining_dah) begin
        if (mismatches < 10) begin
          $display("result mismatch, expected: soc %0d target %0d chg %0b dis %0b rem %0d",
                   want.soc, want.target, want.charge_ok, want.discharge_ok,
                   want.remaining_dah);
          $display("                 actual:   soc %0d target %0d chg %0b dis %0b rem %0d",
                   got.soc, got.target, got.charge_ok, got.discharge_ok, got.remaining_dah);
        end
        mismatches++;
      end
    end
  endfunction
endclass

module tb_battery_soc_coulomb_counter_top;

  localparam int STALL_LIMIT     = 3000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 125;

  typedef enum {RUN_TRICKLE, RUN_CHARGE, RUN_DRAIN, RUN_NOISE} run_kind_t;

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [bscc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bscc_pkg::CFG_DATA_W-1:0]  cfg_data;
  bit                               throttle;
  bit                               gaps_on;
  int                               stall_cycles;
  soc_ledger                        ledger = new();

  bscc_in_if  tick_ch();
  bscc_out_if res_ch();

  battery_soc_coulomb_counter_top uut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (throttle && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_monitor
    soc_out_t got;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        got.soc           = res_ch.soc_centipct;
        got.target        = res_ch.target_soc_centipct;
        got.charge_ok     = res_ch.charge_ok;
        got.discharge_ok  = res_ch.discharge_ok;
        got.remaining_dah = res_ch.remaining_charge_dah;
        ledger.match_result(got);
      end
      if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic put_tick(input tick_t t);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    tick_ch.valid              <= 1'b1;
    tick_ch.motor_current_da   <= t.motor_da;
    tick_ch.charger_current_da <= t.charger_da;
    tick_ch.pack_voltage_dv    <= t.volts_dv;
    tick_ch.elapsed_ms         <= t.elapsed_ms;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    ledger.log_tick(t);
  endtask

  // hold off new ticks until every outstanding result has been transferred
  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (ledger.soc_due.size() != 0);
  endtask

  task automatic write_reg(input logic [bscc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bscc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    ledger.write_reg(idx, data);
  endtask

  task automatic apply_config(input logic [14:0] cap, init, empty, full);
    drain_results();
    write_reg(bscc_pkg::REG_NOMINAL_CAPACITY, cap);
    write_reg(bscc_pkg::REG_INITIAL_CHARGE, init);
    write_reg(bscc_pkg::REG_EMPTY_VOLTAGE, empty);
    write_reg(bscc_pkg::REG_FULL_VOLTAGE, full);
    cfg_we <= 1'b0;
  endtask

  function automatic tick_t make_item(int m, int c, int v, int ms);
    tick_t t;
    t.motor_da   = m[15:0];
    t.charger_da = c[15:0];
    t.volts_dv   = v[14:0];
    t.elapsed_ms = ms[19:0];
    return t;
  endfunction

  function automatic int pick_int(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // weighted towards the empty and full edges of the current voltage window
  function automatic int pick_volts();
    int v;
    case ($urandom_range(0, 4))
      0: v = pick_int(0, 20000);
      1: v = int'(ledger.empty_dv) + pick_int(-600, 600);
      2: v = int'(ledger.full_dv) + pick_int(-600, 600);
      3: v = ($urandom_range(0, 1) ? int'(ledger.empty_dv) : int'(ledger.full_dv))
             + pick_int(-1, 1);
      default: v = pick_int(int'(ledger.empty_dv), int'(ledger.full_dv));
    endcase
    if (v < 0) v = 0;
    if (v > 20000) v = 20000;
    return v;
  endfunction

  function automatic tick_t make_random(run_kind_t kind);
    int m, c, ms;
    case (kind)
      RUN_CHARGE: begin
        if ($urandom_range(0, 1)) begin
          m = -20000; c = 20000; ms = 1048575;
        end else begin
          m = pick_int(-20000, 0); c = pick_int(0, 20000); ms = pick_int(300000, 1048575);
        end
      end
      RUN_DRAIN: begin
        if ($urandom_range(0, 1)) begin
          m = 20000; c = -20000; ms = 1048575;
        end else begin
          m = pick_int(0, 20000); c = pick_int(-20000, 0); ms = pick_int(300000, 1048575);
        end
      end
      RUN_TRICKLE: begin
        m = pick_int(-2000, 2000); c = pick_int(-500, 2000); ms = pick_int(0, 4000);
      end
      default: begin
        m = pick_int(-20000, 20000); c = pick_int(-20000, 20000); ms = pick_int(0, 1048575);
      end
    endcase
    return make_item(m, c, pick_volts(), ms);
  endfunction

  task automatic run_directed();
    put_tick(make_item(20000, -20000, 3000, 1048575));  // first tick: load only
    put_tick(make_item(0, 0, 3250, 0));
    put_tick(make_item(0, 0, 2600, 1000));              // lower zone, bias applied
    put_tick(make_item(0, 0, 0, 1));
    put_tick(make_item(0, 0, 3900, 100));               // upper zone
    put_tick(make_item(0, 0, 20000, 0));                // target clamped
    put_tick(make_item(0, 0, 2799, 0));
    put_tick(make_item(0, 0, 2800, 0));
    put_tick(make_item(0, 0, 3700, 0));
    put_tick(make_item(0, 0, 3701, 0));
    put_tick(make_item(0, 0, 2500, 0));
    put_tick(make_item(20000, -20000, 3250, 1048575));  // counter floors at zero
    put_tick(make_item(0, 1000, 3250, 72000));          // discharge limit exactly
    put_tick(make_item(1, 0, 3250, 1));                 // just under discharge limit
    put_tick(make_item(20000, -20000, 3250, 1048575));
    put_tick(make_item(0, 20000, 3250, 179100));        // charge limit exactly
    put_tick(make_item(0, 360, 3250, 1000));            // just over charge limit
    put_tick(make_item(0, 0, 3250, 0));
    put_tick(make_item(-20000, 20000, 3900, 1048575));
    put_tick(make_item(-20000, 20000, 20000, 1048575));
  endtask

  task automatic run_random();
    int          p, done, k, len;
    run_kind_t   kind;
    logic [14:0] e, f, sw;
    for (p = 0; p < PHASES; p++) begin
      e = 15'($urandom_range(0, 20000));
      f = 15'($urandom_range(0, 20000));
      if (e > f && $urandom_range(0, 3) != 0) begin
        sw = e; e = f; f = sw;
      end
      case (p)
        0: apply_config(15'd1000, 15'($urandom_range(0, 20000)), 15'd2500, 15'd4000);
        1: apply_config(15'd0, 15'd20000, 15'd3000, 15'd3600);     // zero capacity
        2: apply_config(15'd20000, 15'd0, 15'd0, 15'd20000);
        3: apply_config(15'd1, 15'd1000, 15'd4000, 15'd4000);      // empty span
        4: apply_config(15'($urandom_range(1, 20000)), 15'd0, 15'd20000, 15'd0);
        default: apply_config(15'($urandom_range(0, 20000)), 15'($urandom_range(0, 20000)),
                              e, f);
      endcase
      throttle = (p != PHASES - 1);
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        k = $urandom_range(0, 9);
        if (k < 4) kind = RUN_TRICKLE;
        else if (k < 6) kind = RUN_CHARGE;
        else if (k < 8) kind = RUN_DRAIN;
        else kind = RUN_NOISE;
        len = (kind == RUN_CHARGE) ? $urandom_range(10, 60) : $urandom_range(1, 30);
        gaps_on = throttle && $urandom_range(0, 2) != 0;
        repeat (len) begin
          put_tick(make_random(kind));
          done++;
        end
        if ($urandom_range(0, 15) == 0) drain_results();
      end
    end
  endtask

  initial begin
    rst                        <= 1'b1;
    cfg_we                     <= 1'b0;
    cfg_index                  <= bscc_pkg::REG_NOMINAL_CAPACITY;
    cfg_data                   <= '0;
    tick_ch.valid              <= 1'b0;
    tick_ch.motor_current_da   <= '0;
    tick_ch.charger_current_da <= '0;
    tick_ch.pack_voltage_dv    <= '0;
    tick_ch.elapsed_ms         <= '0;
    throttle     = 1'b1;
    gaps_on      = 1'b1;
    stall_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    apply_config(15'd1000, 15'd500, 15'd2500, 15'd4000);
    run_directed();
    run_random();
    drain_results();
    repeat (64) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.soc_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/bscc_pkg.sv
hw/rtl/bscc_in_if.sv
hw/rtl/bscc_out_if.sv
hw/rtl/bscc_div.sv
hw/rtl/battery_soc_coulomb_counter_top.sv
tb/tb_battery_soc_coulomb_counter_top.sv
